>>> hdl/bsce_pkg.sv
`default_nettype none
package bsce_pkg;

  localparam int MAX_CP     = 64;
  localparam int MAX_DEG    = 3;
  localparam int KNOT_DEPTH = MAX_CP + MAX_DEG + 1;
  localparam int BASIS_FRAC = 30;
  localparam int BASIS_W    = BASIS_FRAC + 1;
  localparam int KIDX_W     = $clog2(KNOT_DEPTH);
  localparam int PIDX_W     = $clog2(MAX_CP);
  localparam int CNT_W      = $clog2(MAX_CP + 1);
  localparam int DEG_W      = 2;
  localparam int ACC_W      = 40;
  localparam int QCNT_W     = $clog2(BASIS_FRAC);

  localparam logic [BASIS_W-1:0] BASIS_ONE = {1'b1, {BASIS_FRAC{1'b0}}};

  localparam logic [1:0] OP_KNOT  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         entry_index;
    logic signed [31:0] knot_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] param_u;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  typedef enum logic [2:0] {
    SOP_NONE, SOP_MX, SOP_MY, SOP_MZ, SOP_AZ
  } sum_op_t;

  typedef enum logic [1:0] {
    BW_NONE, BW_INIT, BW_ZERO, BW_SUM
  } bw_src_t;

  typedef struct packed {
    logic              take;
    logic [KIDX_W-1:0] kaddr;
    logic [KIDX_W-1:0] baddr;
    logic [KIDX_W-1:0] waddr;
    bw_src_t           bw;
    logic              cap_ka;
    logic              cap_kb;
    logic              cap_kc;
    logic              cap_kd;
    logic              cap_bi;
    logic              cap_bi1;
    logic              div_start;
    logic              div_right;
    logic              mul0;
    logic              mul1;
    logic              cap_pt;
    sum_op_t           sum_op;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pair_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/bspline_curve_evaluator.sv
// A knot or control point write is taken while idle and leaves busy low.
// An evaluation first seeds the degree-0 basis, then per level writes each pair
// of zero basis entries as zero directly and otherwise runs two divisions of 30
// quotient bits each in the shared divider, then forms the weighted sum.
// One item is worked at a time; out_valid pulses once per evaluation.
// Reset (rst_n low, synchronous) idles the sequencer and restores the registers.
`default_nettype none
module bspline_curve_evaluator import bsce_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers: degree at byte address 0 and the control point
  // count at byte address 4. Only address bit 2 selects the register.
  logic [DEG_W-1:0] degree_r, degree_nxt;
  logic [6:0]       npts_r, npts_nxt;
  logic             cfg_wr;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    degree_nxt = degree_r;
    npts_nxt   = npts_r;
    if (cfg_wr) begin
      if (paddr[2]) begin
        npts_nxt = pwdata[6:0];
      end else begin
        degree_nxt = pwdata[DEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_W'(3);
      npts_r   <= 7'd4;
    end else begin
      degree_r <= degree_nxt;
      npts_r   <= npts_nxt;
    end
  end

  assign prdata = paddr[2] ? {25'd0, npts_r} : {30'd0, degree_r};

  // The sequencer walks the basis triangle in place and then the weighted sum;
  // the datapath holds the tables, the divider and the accumulators.
  bsce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opcode     (in_data.opcode),
    .cfg_degree (degree_r),
    .cfg_npts   (npts_r),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  bsce_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> hdl/bsce_div.sv
`default_nettype none
module bsce_div import bsce_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [32:0]   num,
  input  wire logic signed [32:0]   den,
  output logic                      done,
  output logic [BASIS_W-1:0]        quo
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       den_r, den_nxt;
  logic [BASIS_W-1:0] quo_r, quo_nxt;
  logic [32:0]       dbl;
  logic              ge;

  // Restoring division, one quotient bit per cycle; num >= den gives one and a non-positive operand gives zero at once.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    dbl      = {rem_r, 1'b0};
    ge       = dbl >= {1'b0, den_r};
    if (start) begin
      if (den <= 33'sd0 || num <= 33'sd0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (num >= den) begin
        quo_nxt  = BASIS_ONE;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = num[31:0];
        den_nxt = den[31:0];
        quo_nxt = '0;
        cnt_nxt = '0;
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      rem_nxt = ge ? 32'(dbl - {1'b0, den_r}) : dbl[31:0];
      quo_nxt = {quo_r[BASIS_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QCNT_W'(BASIS_FRAC - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

>>> hdl/bsce_dp.sv
`default_nettype none
module bsce_dp import bsce_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output out_item_t      out_data
);

  logic signed [31:0] knot_mem [KNOT_DEPTH];
  logic [95:0]        pt_mem [MAX_CP];
  logic [BASIS_W-1:0] basis_mem [KNOT_DEPTH];

  logic signed [31:0] krd_r;
  logic [95:0]        prd_r;
  logic [BASIS_W-1:0] brd_r;

  logic signed [31:0] u_r, ka_r, kb_r, kc_r, kd_r;
  logic [BASIS_W-1:0] bi_r, bi1_r, w0_r, w1_r, p0_r, p1_r, b_r;
  logic [95:0]        pt_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] accx_r, accy_r, accz_r;
  out_item_t          out_r;

  logic signed [32:0] dnum, dden;
  logic               ddone;
  logic [BASIS_W-1:0] dquo;
  logic [2*BASIS_W-1:0] m0, m1;
  logic [BASIS_W:0]   psum;
  logic [BASIS_W-1:0] bsum, bwdata;
  logic signed [31:0] coord;
  logic signed [ACC_W-1:0] contrib;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = ~hi;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Left weight uses (u - t[i]) / (t[i+d] - t[i]), right uses
  // (t[i+d+1] - u) / (t[i+d+1] - t[i+1]).
  always_comb begin
    if (cmd.div_right) begin
      dnum = 33'(kd_r) - 33'(u_r);
      dden = 33'(kd_r) - 33'(kb_r);
    end else begin
      dnum = 33'(u_r) - 33'(ka_r);
      dden = 33'(kc_r) - 33'(ka_r);
    end
  end

  bsce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  assign m0   = w0_r * bi_r;
  assign m1   = w1_r * bi1_r;
  assign psum = {1'b0, p0_r} + {1'b0, p1_r};
  assign bsum = (psum > {1'b0, BASIS_ONE}) ? BASIS_ONE : psum[BASIS_W-1:0];

  always_comb begin
    case (cmd.bw)
      BW_INIT: bwdata = (u_r >= ka_r && u_r < krd_r) ? BASIS_ONE : '0;
      BW_SUM:  bwdata = bsum;
      default: bwdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.sum_op)
      SOP_MY:  coord = pt_r[63:32];
      SOP_MZ:  coord = pt_r[31:0];
      default: coord = pt_r[95:64];
    endcase
  end

  // Floor of the Q2.30 by Q16.16 product back to Q16.16.
  assign contrib = ACC_W'($signed(prod_r[63:BASIS_FRAC]));

  always_ff @(posedge clk) begin
    if (cmd.take && in_data.opcode == OP_KNOT &&
        in_data.entry_index < 7'(KNOT_DEPTH)) begin
      knot_mem[in_data.entry_index[KIDX_W-1:0]] <= in_data.knot_value;
    end
    if (cmd.take && in_data.opcode == OP_POINT &&
        in_data.entry_index < 7'(MAX_CP)) begin
      pt_mem[in_data.entry_index[PIDX_W-1:0]] <=
        {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    end
    if (cmd.bw != BW_NONE) begin
      basis_mem[cmd.waddr] <= bwdata;
    end
    krd_r <= knot_mem[cmd.kaddr];
    prd_r <= pt_mem[cmd.baddr[PIDX_W-1:0]];
    brd_r <= basis_mem[cmd.baddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      u_r    <= in_data.param_u;
      accx_r <= '0;
      accy_r <= '0;
      accz_r <= '0;
    end
    if (cmd.cap_ka) ka_r <= krd_r;
    if (cmd.cap_kb) kb_r <= krd_r;
    if (cmd.cap_kc) kc_r <= krd_r;
    if (cmd.cap_kd) kd_r <= krd_r;
    if (cmd.cap_bi) bi_r <= brd_r;
    if (cmd.cap_bi1) bi1_r <= brd_r;
    if (ddone) begin
      if (cmd.div_right) begin
        w1_r <= dquo;
      end else begin
        w0_r <= dquo;
      end
    end
    if (cmd.mul0) p0_r <= m0[BASIS_FRAC +: BASIS_W];
    if (cmd.mul1) p1_r <= m1[BASIS_FRAC +: BASIS_W];
    if (cmd.cap_pt) begin
      b_r  <= brd_r;
      pt_r <= prd_r;
    end
    if (cmd.sum_op == SOP_MX || cmd.sum_op == SOP_MY || cmd.sum_op == SOP_MZ) begin
      prod_r <= $signed({1'b0, b_r}) * coord;
    end
    if (cmd.sum_op == SOP_MY) accx_r <= accx_r + contrib;
    if (cmd.sum_op == SOP_MZ) accy_r <= accy_r + contrib;
    if (cmd.sum_op == SOP_AZ) accz_r <= accz_r + contrib;
    if (cmd.out_load) begin
      out_r.out_x <= sat32(accx_r);
      out_r.out_y <= sat32(accy_r);
      out_r.out_z <= sat32(accz_r);
    end
  end

  assign stat.div_done  = ddone;
  assign stat.pair_zero = (bi_r == '0) && (brd_r == '0);
  assign out_data       = out_r;

endmodule
`default_nettype wire

>>> hdl/bsce_ctrl.sv
`default_nettype none
module bsce_ctrl import bsce_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       opcode,
  input  wire logic [DEG_W-1:0] cfg_degree,
  input  wire logic [6:0]       cfg_npts,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd,
  output logic                  busy,
  output logic                  out_valid
);

  typedef enum logic [4:0] {
    S_IDLE, S_IA0, S_IA1, S_IWR,
    S_BR0, S_BR1, S_BCHK,
    S_K0, S_K1, S_K2, S_K3, S_K4,
    S_D0S, S_D0W, S_D1S, S_D1W,
    S_MUL0, S_MUL1, S_BWR,
    S_SR, S_SCAP, S_SMX, S_SMY, S_SMZ, S_SAZ,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIDX_W-1:0] i_r, i_nxt;
  logic [DEG_W-1:0]  d_r, d_nxt;
  logic [KIDX_W-1:0] m_r, m_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [DEG_W-1:0]  p_r, p_nxt;
  logic              ov_r, ov_nxt;
  logic [CNT_W-1:0]  n_eff;
  logic [KIDX_W-1:0] i_inc, i_pd, i_pd1;
  logic              at_end;

  assign n_eff = (cfg_npts > 7'(MAX_CP)) ? CNT_W'(MAX_CP) : cfg_npts;
  assign i_inc = i_r + 1'b1;
  assign i_pd  = i_r + KIDX_W'(d_r);
  assign i_pd1 = i_pd + 1'b1;
  // The level ends once i + 1 + d reaches m.
  assign at_end = !(i_pd1 < m_r);

  always_comb begin
    cmd       = '0;
    cmd.bw    = BW_NONE;
    cmd.sum_op = SOP_NONE;
    cmd.waddr = i_r;
    cmd.baddr = i_r;
    cmd.kaddr = i_r;
    state_nxt = state_r;
    i_nxt     = i_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    ov_nxt    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cmd.take = start;
        if (start && opcode == OP_EVAL) begin
          p_nxt = cfg_degree;
          n_nxt = n_eff;
          m_nxt = KIDX_W'(n_eff) + KIDX_W'(cfg_degree);
          i_nxt = '0;
          state_nxt = (n_eff == '0) ? S_DONE : S_IA0;
        end
      end
      S_IA0: begin
        cmd.kaddr = i_r;
        state_nxt = S_IA1;
      end
      S_IA1: begin
        cmd.kaddr  = i_inc;
        cmd.cap_ka = 1'b1;
        state_nxt  = S_IWR;
      end
      S_IWR: begin
        cmd.bw = BW_INIT;
        if (i_inc < m_r) begin
          i_nxt     = i_inc;
          state_nxt = S_IA0;
        end else if (p_r != '0 && KIDX_W'(1) < m_r) begin
          d_nxt     = DEG_W'(1);
          i_nxt     = '0;
          state_nxt = S_BR0;
        end else begin
          i_nxt     = '0;
          state_nxt = S_SR;
        end
      end
      S_BR0: begin
        cmd.baddr = i_r;
        state_nxt = S_BR1;
      end
      S_BR1: begin
        cmd.baddr  = i_inc;
        cmd.cap_bi = 1'b1;
        state_nxt  = S_BCHK;
      end
      S_BCHK, S_BWR: begin
        if (state_r == S_BCHK) begin
          cmd.cap_bi1 = 1'b1;
        end
        if (state_r == S_BCHK && !stat.pair_zero) begin
          state_nxt = S_K0;
        end else begin
          cmd.bw = (state_r == S_BCHK) ? BW_ZERO : BW_SUM;
          if (!at_end) begin
            i_nxt     = i_inc;
            state_nxt = S_BR0;
          end else if (d_r < p_r && KIDX_W'(d_r) + 1'b1 < m_r) begin
            d_nxt     = d_r + 1'b1;
            i_nxt     = '0;
            state_nxt = S_BR0;
          end else begin
            i_nxt     = '0;
            state_nxt = S_SR;
          end
        end
      end
      S_K0: begin
        cmd.kaddr = i_r;
        state_nxt = S_K1;
      end
      S_K1: begin
        cmd.kaddr  = i_pd;
        cmd.cap_ka = 1'b1;
        state_nxt  = S_K2;
      end
      S_K2: begin
        cmd.kaddr  = i_inc;
        cmd.cap_kc = 1'b1;
        state_nxt  = S_K3;
      end
      S_K3: begin
        cmd.kaddr  = i_pd1;
        cmd.cap_kb = 1'b1;
        state_nxt  = S_K4;
      end
      S_K4: begin
        cmd.cap_kd = 1'b1;
        state_nxt  = S_D0S;
      end
      S_D0S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_D0W;
      end
      S_D0W: begin
        if (stat.div_done) begin
          state_nxt = S_D1S;
        end
      end
      S_D1S: begin
        cmd.div_right = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_D1W;
      end
      S_D1W: begin
        cmd.div_right = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_BWR;
      end
      S_SR: begin
        cmd.baddr = i_r;
        state_nxt = S_SCAP;
      end
      S_SCAP: begin
        cmd.cap_pt = 1'b1;
        state_nxt  = S_SMX;
      end
      S_SMX: begin
        cmd.sum_op = SOP_MX;
        state_nxt  = S_SMY;
      end
      S_SMY: begin
        cmd.sum_op = SOP_MY;
        state_nxt  = S_SMZ;
      end
      S_SMZ: begin
        cmd.sum_op = SOP_MZ;
        state_nxt  = S_SAZ;
      end
      S_SAZ: begin
        cmd.sum_op = SOP_AZ;
        if (CNT_W'(i_inc) < n_r) begin
          i_nxt     = i_inc;
          state_nxt = S_SR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        ov_nxt       = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    i_r <= i_nxt;
    d_r <= d_nxt;
    m_r <= m_nxt;
    n_r <= n_nxt;
    p_r <= p_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire
